// File: design/triangle_closest_point_to_origin_assert.svh
// Assertion macros for the triangle closest-point block.
`ifndef TRIANGLE_CLOSEST_POINT_TO_ORIGIN_ASSERT_SVH
`define TRIANGLE_CLOSEST_POINT_TO_ORIGIN_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define TCP_ASSERT_IMP(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tcp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define TCP_ASSERT_NXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tcp assertion failed");

`endif

// File: design/tcp_pkg.sv
// Shared types and constants for the triangle closest-point block.
package tcp_pkg;

    // Operand slice width of the pipelined multipliers (17 x 17 signed cells + sign).
    localparam int MUL_CHUNK = 17;

    // Per-beat flags that ride along with the divider data.
    typedef struct packed {
        logic pos;      // determinant > 0
        logic enclosed; // lambdas inside the triangle
    } tag_t;

endpackage

// File: design/tcp_mul.sv
// Three-stage pipelined signed multiplier built from small partial products.
module tcp_mul #(
    parameter int WA = 36,
    parameter int WB = 36
) (
    input  logic                    clk,
    input  logic signed [WA-1:0]    a,
    input  logic signed [WB-1:0]    b,
    output logic signed [WA+WB-1:0] p
);
    import tcp_pkg::*;

    localparam int CH = MUL_CHUNK;
    localparam int NA = (WA + CH - 1) / CH;
    localparam int NB = (WB + CH - 1) / CH;
    localparam int WP = WA + WB;

    logic signed [NA*CH-1:0] a_ext;
    logic signed [NB*CH-1:0] b_ext;
    logic signed [CH:0]      ach [NA];
    logic signed [CH:0]      bch [NB];
    logic signed [2*CH+1:0]  pp_reg [NA][NB];
    logic signed [WP-1:0]    row_next [NA];
    logic signed [WP-1:0]    row_reg [NA];
    logic signed [WP-1:0]    p_next;
    logic signed [WP-1:0]    p_reg;

    assign a_ext = (NA*CH)'(a);
    assign b_ext = (NB*CH)'(b);

    // low slices unsigned, top slice carries the sign
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            if (i == NA - 1)
                ach[i] = $signed({a_ext[NA*CH-1], a_ext[i*CH +: CH]});
            else
                ach[i] = $signed({1'b0, a_ext[i*CH +: CH]});
        end
        for (int j = 0; j < NB; j++)
        begin
            if (j == NB - 1)
                bch[j] = $signed({b_ext[NB*CH-1], b_ext[j*CH +: CH]});
            else
                bch[j] = $signed({1'b0, b_ext[j*CH +: CH]});
        end
    end

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
                row_next[i] = row_next[i] + (WP'(pp_reg[i][j]) <<< (j*CH));
        end
        p_next = '0;
        for (int i = 0; i < NA; i++)
            p_next = p_next + (row_reg[i] <<< (i*CH));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
                pp_reg[i][j] <= ach[i] * bch[j];
            row_reg[i] <= row_next[i];
        end
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// File: design/tcp_div.sv
// Pipelined restoring divider: round(num / den) to nearest, ties away, saturated.
module tcp_div #(
    parameter int W  = 16,
    parameter int NW = 96,
    parameter int DW = 73
) (
    input  logic                 clk,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    input  tcp_pkg::tag_t        tag_in,
    output logic signed [W-1:0]  q,
    output tcp_pkg::tag_t        tag_out
);
    import tcp_pkg::*;

    localparam int RW = NW + W + 2;
    localparam int NS = W + 1;
    localparam logic [W+1:0] MAXP = (W+2)'((1 << (W-1)) - 1);
    localparam logic [W+1:0] MINM = (W+2)'(1 << (W-1));
    localparam logic [W-1:0] QMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] QMIN = {1'b1, {(W-1){1'b0}}};

    logic [NW-1:0]   mag;
    logic [RW-1:0]   rem_reg  [NS+1];
    logic [DW-1:0]   den_reg  [NS+1];
    logic [W:0]      quo_reg  [NS+1];
    logic            neg_reg  [NS+1];
    logic            over_reg [NS+1];
    tag_t            tag_reg  [NS+1];
    logic            rnd;
    logic [W+1:0]    qm;
    logic [W-1:0]    q_next;
    logic [W-1:0]    q_reg;
    tag_t            tag_out_reg;

    assign mag = num[NW-1] ? NW'(-num) : NW'(num);

    // stage 0: magnitude and out-of-range check (quotient >= 2^(W+1))
    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= RW'(mag);
        den_reg[0]  <= den;
        quo_reg[0]  <= '0;
        neg_reg[0]  <= num[NW-1];
        over_reg[0] <= RW'(mag) >= (RW'(den) << (W+1));
        tag_reg[0]  <= tag_in;
    end

    // one quotient bit per stage, MSB first
    for (genvar s = 1; s <= NS; s++)
    begin : g_bit
        localparam int B = NS - s;
        logic [RW-1:0] sh;
        logic          ge;
        assign sh = RW'(den_reg[s-1]) << B;
        assign ge = rem_reg[s-1] >= sh;
        always_ff @(posedge clk)
        begin
            rem_reg[s]  <= ge ? rem_reg[s-1] - sh : rem_reg[s-1];
            quo_reg[s]  <= quo_reg[s-1] | ((W+1)'(ge) << B);
            den_reg[s]  <= den_reg[s-1];
            neg_reg[s]  <= neg_reg[s-1];
            over_reg[s] <= over_reg[s-1];
            tag_reg[s]  <= tag_reg[s-1];
        end
    end

    // round half up on the magnitude, then clamp to the signed range
    assign rnd = ((RW+1)'(rem_reg[NS]) << 1) >= (RW+1)'(den_reg[NS]);
    assign qm  = (W+2)'(quo_reg[NS]) + (W+2)'(rnd);

    always_comb
    begin
        if (neg_reg[NS])
        begin
            if (over_reg[NS] || qm > MINM)
                q_next = QMIN;
            else
                q_next = W'((W+2)'(0) - qm);
        end
        else
        begin
            if (over_reg[NS] || qm > MAXP)
                q_next = QMAX;
            else
                q_next = W'(qm);
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        tag_out_reg <= tag_reg[NS];
    end

    assign q       = q_reg;
    assign tag_out = tag_out_reg;

endmodule

// File: design/triangle_closest_point_to_origin.sv
// Top level: closest point of a triangle's plane to the origin, fully pipelined.
//
// Usage:
//   Command channel: a triangle beat (p0, p1, p2, signed fixed point) is taken
//   at every rising edge with start high and busy low. busy is held low: the
//   pipeline never stalls, so one beat may enter in every cycle.
//   Result channel: done is high for one cycle per result beat, with near_x/y/z, dist_squared,
//   valid_res and inside_res. The receiver cannot hold results off.
//   Throughput: one triangle per cycle. The pipeline chain runs edges ->
//   dot products -> 3-stage wide multiplier (det, lambdas) -> 3-stage wide
//   multiplier (numerators) -> restoring divider with one quotient bit per
//   stage -> squares -> sum.
//   Reset: rst_n clears only the beat valid pipeline; beats in flight are
//   dropped, no done pulse appears for them.
//   When det <= 0 the point and dist_squared are zero and valid_res is 0;
//   inside_res is always reported from the lambdas.
module triangle_closest_point_to_origin #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] p0_x,
    input  logic signed [COORD_WIDTH-1:0] p0_y,
    input  logic signed [COORD_WIDTH-1:0] p0_z,
    input  logic signed [COORD_WIDTH-1:0] p1_x,
    input  logic signed [COORD_WIDTH-1:0] p1_y,
    input  logic signed [COORD_WIDTH-1:0] p1_z,
    input  logic signed [COORD_WIDTH-1:0] p2_x,
    input  logic signed [COORD_WIDTH-1:0] p2_y,
    input  logic signed [COORD_WIDTH-1:0] p2_z,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] near_x,
    output logic signed [COORD_WIDTH-1:0] near_y,
    output logic signed [COORD_WIDTH-1:0] near_z,
    output logic [31:0]                   dist_squared,
    output logic                          valid_res,
    output logic                          inside_res
);
    import tcp_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int VW  = W + 1;           // edge vector width
    localparam int PW  = 2 * VW;          // single dot-product term
    localparam int DW  = 2 * W + 4;       // dot products
    localparam int MW  = 2 * DW;          // det / lambda terms
    localparam int LW  = MW + 1;          // det, lambda1, lambda2
    localparam int QW  = LW + VW;         // numerator terms
    localparam int NW  = QW + 2;          // numerator
    localparam int SW  = (2 * W + 2 > 33) ? 2 * W + 2 : 33;
    localparam int LAT = W + 17;          // start to done
    localparam int DLY = 6;               // edges held from stage 2 to stage 8

    // beat valid pipeline, index n is stage n+1
    logic [LAT-1:0] vld_reg;

    // stage 1: captured vertices
    logic signed [W-1:0] pa_reg [3];
    logic signed [W-1:0] pb_reg [3];
    logic signed [W-1:0] pc_reg [3];

    // stage 2: origin vertex and edges
    logic signed [VW-1:0] p0_reg [3];
    logic signed [VW-1:0] v1_reg [3];
    logic signed [VW-1:0] v2_reg [3];

    // stage 3: dot product terms
    logic signed [PW-1:0] t11_reg [3];
    logic signed [PW-1:0] t12_reg [3];
    logic signed [PW-1:0] t22_reg [3];
    logic signed [PW-1:0] tp1_reg [3];
    logic signed [PW-1:0] tp2_reg [3];

    // stage 4: dot products
    logic signed [DW-1:0] d11_reg, d12_reg, d22_reg, dp1_reg, dp2_reg;

    // stage 7: wide products
    logic signed [MW-1:0] m_1122, m_1212, m_p212, m_p122, m_p112, m_p211;

    // stage 8: det and lambdas
    logic signed [LW-1:0] det_reg, l1_reg, l2_reg;

    // edge vectors held until the second multiply
    logic signed [VW-1:0] p0d_reg [DLY][3];
    logic signed [VW-1:0] v1d_reg [DLY][3];
    logic signed [VW-1:0] v2d_reg [DLY][3];

    // stage 9..12 flags, stage 9..12 det
    logic [LW+1:0]        rest;
    tag_t                 tag_reg [4];
    logic signed [LW-1:0] detd_reg [4];

    // stage 11: numerator terms, stage 12: numerators
    logic signed [QW-1:0] n0 [3];
    logic signed [QW-1:0] n1 [3];
    logic signed [QW-1:0] n2 [3];
    logic signed [NW-1:0] num_reg [3];

    // divider outputs (stage W+15)
    logic signed [W-1:0]  qd [3];
    tag_t                 tag_q;
    tag_t                 tag_qy;
    tag_t                 tag_qz;

    // stage W+16: masked point and squares
    logic signed [W-1:0]  nr_reg [3];
    logic [2*W-1:0]       sq_reg [3];
    tag_t                 tag_s_reg;

    // stage W+17: outputs
    logic [SW-1:0]        sum;
    logic signed [W-1:0]  out_reg [3];
    logic [31:0]          dist_reg;
    tag_t                 tag_o_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
    end

    always_ff @(posedge clk)
    begin
        pa_reg[0] <= p0_x; pa_reg[1] <= p0_y; pa_reg[2] <= p0_z;
        pb_reg[0] <= p1_x; pb_reg[1] <= p1_y; pb_reg[2] <= p1_z;
        pc_reg[0] <= p2_x; pc_reg[1] <= p2_y; pc_reg[2] <= p2_z;
        for (int k = 0; k < 3; k++)
        begin
            p0_reg[k]  <= VW'(pa_reg[k]);
            v1_reg[k]  <= VW'(pb_reg[k]) - VW'(pa_reg[k]);
            v2_reg[k]  <= VW'(pc_reg[k]) - VW'(pa_reg[k]);
            t11_reg[k] <= v1_reg[k] * v1_reg[k];
            t12_reg[k] <= v1_reg[k] * v2_reg[k];
            t22_reg[k] <= v2_reg[k] * v2_reg[k];
            tp1_reg[k] <= p0_reg[k] * v1_reg[k];
            tp2_reg[k] <= p0_reg[k] * v2_reg[k];
        end
        d11_reg <= DW'(t11_reg[0]) + DW'(t11_reg[1]) + DW'(t11_reg[2]);
        d12_reg <= DW'(t12_reg[0]) + DW'(t12_reg[1]) + DW'(t12_reg[2]);
        d22_reg <= DW'(t22_reg[0]) + DW'(t22_reg[1]) + DW'(t22_reg[2]);
        dp1_reg <= DW'(tp1_reg[0]) + DW'(tp1_reg[1]) + DW'(tp1_reg[2]);
        dp2_reg <= DW'(tp2_reg[0]) + DW'(tp2_reg[1]) + DW'(tp2_reg[2]);
    end

    // det = d11*d22 - d12^2, l1 = p2d*d12 - p1d*d22, l2 = p1d*d12 - p2d*d11
    tcp_mul #(.WA(DW), .WB(DW)) u_m1122 (.clk(clk), .a(d11_reg), .b(d22_reg), .p(m_1122));
    tcp_mul #(.WA(DW), .WB(DW)) u_m1212 (.clk(clk), .a(d12_reg), .b(d12_reg), .p(m_1212));
    tcp_mul #(.WA(DW), .WB(DW)) u_mp212 (.clk(clk), .a(dp2_reg), .b(d12_reg), .p(m_p212));
    tcp_mul #(.WA(DW), .WB(DW)) u_mp122 (.clk(clk), .a(dp1_reg), .b(d22_reg), .p(m_p122));
    tcp_mul #(.WA(DW), .WB(DW)) u_mp112 (.clk(clk), .a(dp1_reg), .b(d12_reg), .p(m_p112));
    tcp_mul #(.WA(DW), .WB(DW)) u_mp211 (.clk(clk), .a(dp2_reg), .b(d11_reg), .p(m_p211));

    always_ff @(posedge clk)
    begin
        det_reg <= LW'(m_1122) - LW'(m_1212);
        l1_reg  <= LW'(m_p212) - LW'(m_p122);
        l2_reg  <= LW'(m_p112) - LW'(m_p211);
        for (int k = 0; k < 3; k++)
        begin
            p0d_reg[0][k] <= p0_reg[k];
            v1d_reg[0][k] <= v1_reg[k];
            v2d_reg[0][k] <= v2_reg[k];
            for (int i = 1; i < DLY; i++)
            begin
                p0d_reg[i][k] <= p0d_reg[i-1][k];
                v1d_reg[i][k] <= v1d_reg[i-1][k];
                v2d_reg[i][k] <= v2d_reg[i-1][k];
            end
        end
    end

    // inside: l1 >= 0, l2 >= 0, det - l1 - l2 >= 0
    assign rest = (LW+2)'(det_reg) - (LW+2)'(l1_reg) - (LW+2)'(l2_reg);

    always_ff @(posedge clk)
    begin
        tag_reg[0].pos      <= ~det_reg[LW-1] & (|det_reg);
        tag_reg[0].enclosed <= ~l1_reg[LW-1] & ~l2_reg[LW-1] & ~rest[LW+1];
        detd_reg[0]         <= det_reg;
        for (int i = 1; i < 4; i++)
        begin
            tag_reg[i]  <= tag_reg[i-1];
            detd_reg[i] <= detd_reg[i-1];
        end
    end

    // numerator per axis: p0*det + l1*v1 + l2*v2
    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        tcp_mul #(.WA(LW), .WB(VW)) u_n0 (
            .clk(clk), .a(det_reg), .b(p0d_reg[DLY-1][k]), .p(n0[k]));
        tcp_mul #(.WA(LW), .WB(VW)) u_n1 (
            .clk(clk), .a(l1_reg), .b(v1d_reg[DLY-1][k]), .p(n1[k]));
        tcp_mul #(.WA(LW), .WB(VW)) u_n2 (
            .clk(clk), .a(l2_reg), .b(v2d_reg[DLY-1][k]), .p(n2[k]));

        always_ff @(posedge clk)
        begin
            num_reg[k] <= NW'(n0[k]) + NW'(n1[k]) + NW'(n2[k]);
        end
    end

    tcp_div #(.W(W), .NW(NW), .DW(LW)) u_div_x (
        .clk(clk), .num(num_reg[0]), .den(detd_reg[3]), .tag_in(tag_reg[3]),
        .q(qd[0]), .tag_out(tag_q));
    tcp_div #(.W(W), .NW(NW), .DW(LW)) u_div_y (
        .clk(clk), .num(num_reg[1]), .den(detd_reg[3]), .tag_in(tag_reg[3]),
        .q(qd[1]), .tag_out(tag_qy));
    tcp_div #(.W(W), .NW(NW), .DW(LW)) u_div_z (
        .clk(clk), .num(num_reg[2]), .den(detd_reg[3]), .tag_in(tag_reg[3]),
        .q(qd[2]), .tag_out(tag_qz));

    // degenerate triangles give a zero point; squares follow from it
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            nr_reg[k] <= tag_q.pos ? qd[k] : '0;
            sq_reg[k] <= tag_q.pos ? (2*W)'((2*W)'(qd[k]) * (2*W)'(qd[k])) : '0;
        end
        tag_s_reg <= tag_q;
    end

    assign sum = SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            out_reg[k] <= nr_reg[k];
        dist_reg  <= (|sum[SW-1:32]) ? 32'hFFFF_FFFF : sum[31:0];
        tag_o_reg <= tag_s_reg;
    end

    assign done         = vld_reg[LAT-1];
    assign near_x       = out_reg[0];
    assign near_y       = out_reg[1];
    assign near_z       = out_reg[2];
    assign dist_squared = dist_reg;
    assign valid_res    = tag_o_reg.pos;
    assign inside_res   = tag_o_reg.enclosed;

`include "triangle_closest_point_to_origin_assert.svh"

    // every result beat traces back to a start that entered the pipeline
    `TCP_ASSERT_IMP(a_done_latency, done, $past(start, LAT))
    // a degenerate triangle reports the origin with zero distance
    `TCP_ASSERT_IMP(a_invalid_zero, done && !valid_res,
        near_x == '0 && near_y == '0 && near_z == '0 && dist_squared == '0)
    // a zero point must carry a zero distance
    `TCP_ASSERT_IMP(a_zero_dist, done && near_x == '0 && near_y == '0 && near_z == '0,
        dist_squared == '0)
    // the strobe is a single pulse unless another beat follows right behind
    `TCP_ASSERT_NXT(a_done_pulse, done && !vld_reg[LAT-2], !done)
    // the three divider lanes carry the same flags for a live beat
    `TCP_ASSERT_IMP(a_tag_lanes, vld_reg[LAT-3], tag_qy == tag_q && tag_qz == tag_q)

endmodule

// File: tb/triangle_closest_point_to_origin_checker.sv
// Checker for the triangle closest-point block: predicts and compares result beats.
module triangle_closest_point_to_origin_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] p0_x,
    input  logic signed [15:0] p0_y,
    input  logic signed [15:0] p0_z,
    input  logic signed [15:0] p1_x,
    input  logic signed [15:0] p1_y,
    input  logic signed [15:0] p1_z,
    input  logic signed [15:0] p2_x,
    input  logic signed [15:0] p2_y,
    input  logic signed [15:0] p2_z,
    input  logic               done,
    input  logic signed [15:0] near_x,
    input  logic signed [15:0] near_y,
    input  logic signed [15:0] near_z,
    input  logic [31:0]        dist_squared,
    input  logic               valid_res,
    input  logic               inside_res,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [191:0] wide_t;
    typedef logic signed [15:0]  coord_t;

    typedef struct {
        coord_t      pt[3];
        logic [31:0] dsq;
        logic        valid;
        logic        enclosed;
    } nearest_t;

    nearest_t nearest_q[$];

    // exact plane projection, rounded half away from zero, saturated
    function automatic nearest_t project_origin(coord_t c[9]);
        longint p[3], a[3], b[3];
        longint d11, d12, d22, pa, pb, val, sum;
        wide_t det, l1, l2, num, mag, q, rem;
        nearest_t r;
        d11 = 0; d12 = 0; d22 = 0; pa = 0; pb = 0; sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            p[k] = c[k];
            a[k] = longint'(c[3+k]) - p[k];
            b[k] = longint'(c[6+k]) - p[k];
            d11 += a[k] * a[k];
            d12 += a[k] * b[k];
            d22 += b[k] * b[k];
            pa  += p[k] * a[k];
            pb  += p[k] * b[k];
        end
        det = wide_t'(d11) * wide_t'(d22) - wide_t'(d12) * wide_t'(d12);
        l1  = wide_t'(pb) * wide_t'(d12) - wide_t'(pa) * wide_t'(d22);
        l2  = wide_t'(pa) * wide_t'(d12) - wide_t'(pb) * wide_t'(d11);
        r.valid    = det > 0;
        r.enclosed = (l1 >= 0) && (l2 >= 0) && ((det - (l1 + l2)) >= 0);
        for (int k = 0; k < 3; k++)
        begin
            val = 0;
            if (r.valid)
            begin
                num = wide_t'(p[k]) * det + l1 * wide_t'(a[k]) + l2 * wide_t'(b[k]);
                mag = (num < 0) ? -num : num;
                q   = mag / det;
                rem = mag % det;
                if (rem * 2 >= det)
                    q = q + 1;
                if (num < 0)
                    val = (q > 32768) ? -32768 : -longint'(q);
                else
                    val = (q > 32767) ? 32767 : longint'(q);
            end
            r.pt[k] = coord_t'(val);
            sum += val * val;
        end
        r.dsq = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        return r;
    endfunction

    task automatic report(string what, longint want, longint got);
        $display("%0t mismatch %s: expected %0d got %0d", $realtime, what, want, got);
        errors++;
    endtask

    always @(posedge clk)
    begin
        coord_t   c[9];
        nearest_t e;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                c = '{p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z};
                nearest_q = {nearest_q, project_origin(c)};
            end
            if (done)
            begin
                if (nearest_q.size() == 0)
                    report("unexpected result beat", 0, 1);
                else
                begin
                    e = nearest_q.pop_front();
                    if (near_x !== e.pt[0]) report("near_x", e.pt[0], near_x);
                    if (near_y !== e.pt[1]) report("near_y", e.pt[1], near_y);
                    if (near_z !== e.pt[2]) report("near_z", e.pt[2], near_z);
                    if (dist_squared !== e.dsq) report("dist_squared", e.dsq, dist_squared);
                    if (valid_res !== e.valid) report("valid_res", e.valid, valid_res);
                    if (inside_res !== e.enclosed)
                        report("inside_res", e.enclosed, inside_res);
                end
            end
            pending = nearest_q.size();
        end
    end
endmodule

// File: tb/triangle_closest_point_to_origin_test.sv
// Top of the triangle closest-point testbench: clock, reset, stimulus and verdict.
module triangle_closest_point_to_origin_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [15:0] coord_t;

    localparam int IDLE_LIMIT = 2000;   // cycles with no beat on either side
    localparam int DRAIN_WAIT = 60;     // extra wait after the scoreboard empties

    logic   clk;
    logic   rst_n;
    logic   start;
    logic   busy;
    coord_t p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z;
    logic   done;
    coord_t near_x, near_y, near_z;
    logic [31:0] dist_squared;
    logic   valid_res;
    logic   inside_res;
    int     errors;
    int     pending;
    int     idle_cycles;

    triangle_closest_point_to_origin dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
        .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
        .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
        .done(done), .near_x(near_x), .near_y(near_y), .near_z(near_z),
        .dist_squared(dist_squared), .valid_res(valid_res), .inside_res(inside_res)
    );

    triangle_closest_point_to_origin_checker scoreboard (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .p0_x(p0_x), .p0_y(p0_y), .p0_z(p0_z),
        .p1_x(p1_x), .p1_y(p1_y), .p1_z(p1_z),
        .p2_x(p2_x), .p2_y(p2_y), .p2_z(p2_z),
        .done(done), .near_x(near_x), .near_y(near_y), .near_z(near_z),
        .dist_squared(dist_squared), .valid_res(valid_res), .inside_res(inside_res),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a run that stops moving beats is a failure.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Gap mode: 0 = back to back, else a gap drawn at random per beat.
    int gap_mode;

    // One command beat; held until the block takes it, then an optional gap.
    task automatic send_triangle(coord_t c[9]);
        int gap;
        start <= 1'b1;
        {p0_x, p0_y, p0_z} <= {c[0], c[1], c[2]};
        {p1_x, p1_y, p1_z} <= {c[3], c[4], c[5]};
        {p2_x, p2_y, p2_z} <= {c[6], c[7], c[8]};
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        gap = (gap_mode == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Coordinate drawn by flavor: full range, extremes, small values, or a mix of full range and extremes.
    function automatic coord_t pick_coord(int flavor);
        case (flavor)
            0: return coord_t'($urandom);
            1: return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            2: return coord_t'($urandom_range(0, 2047)) - 16'sd1024;
            default:
            begin
                if ($urandom_range(0, 3) == 0)
                    return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
                return coord_t'($urandom);
            end
        endcase
    endfunction

    coord_t tri_c[9];

    task automatic random_triangle();
        int flavor;
        flavor = $urandom_range(0, 3);
        for (int i = 0; i < 9; i++)
            tri_c[i] = pick_coord(flavor);
        // degenerate shapes: repeated vertex or collinear vertices
        case ($urandom_range(0, 9))
            0: for (int i = 0; i < 3; i++) tri_c[3+i] = tri_c[i];
            1: for (int i = 0; i < 3; i++) tri_c[6+i] = tri_c[3+i];
            2: for (int i = 0; i < 3; i++) tri_c[6+i] = tri_c[i] + (tri_c[3+i] - tri_c[i]) / 2;
            default: ;
        endcase
    endtask

    initial
    begin
        start    = 1'b0;
        {p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z} = '0;
        rst_n    = 1'b0;
        gap_mode = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: degenerate, inside, outside, extremes, saturation
        send_triangle('{0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_triangle('{256, 0, 0, 512, 0, 0, 768, 0, 0});
        send_triangle('{-256, -256, 256, 512, -256, 256, -256, 512, 256});
        send_triangle('{256, 256, 256, 768, 256, 256, 256, 768, 256});
        send_triangle('{256, 0, 0, 0, 256, 0, 0, 0, 256});
        send_triangle('{-512, 0, 0, 0, -512, 0, 0, 0, -512});
        send_triangle('{2560, 0, 0, 0, 2560, 0, 0, 0, 2560});
        send_triangle('{1, 0, 0, 0, 1, 0, 0, 0, 1});
        send_triangle('{32767, 32767, 32767, -32768, -32768, -32768,
                        32767, -32768, 32767});
        send_triangle('{-32768, -32768, -32768, 32767, -32768, -32768,
                        -32768, 32767, -32768});
        send_triangle('{32767, 32767, 32767, 32767, 32767, 32766,
                        32766, 32767, 32767});
        send_triangle('{-32768, -32768, -32768, -32768, -32768, -32767,
                        -32767, -32768, -32768});
        send_triangle('{32767, -32768, 0, 32767, 32767, 0, -32768, 32767, 0});
        send_triangle('{32767, 0, 1, 32767, 1, 0, 32766, 0, 0});
        send_triangle('{-1, -1, -1, -1, -1, -1, -1, -1, -1});
        send_triangle('{0, 0, 256, 256, 0, 256, 0, 256, 256});
        send_triangle('{1000, 1000, 300, 1300, 1000, 300, 1000, 1300, 300});

        // pause: hold off until the pipeline has fully drained
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);

        // random: stretches of back-to-back beats mixed with stretches of gapped ones
        for (int n = 0; n < 1200; n++)
        begin
            if (n % 100 == 0)
                gap_mode = $urandom_range(0, 2);
            random_triangle();
            send_triangle(tri_c);
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: files.f
+incdir+design
design/tcp_pkg.sv
design/tcp_mul.sv
design/tcp_div.sv
design/triangle_closest_point_to_origin.sv
tb/triangle_closest_point_to_origin_checker.sv
tb/triangle_closest_point_to_origin_test.sv
